@@ rtl/core/tccd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ternary comma code decoder package
// Shared constants and types for the decoder front end, queue and back end.
// ----------------------------------------------------------------------------
package tccd_pkg;

	localparam int unsigned DIGITS_PER_BYTE = 4;
	localparam int unsigned DIGIT_W         = 2;
	localparam int unsigned BYTE_W          = DIGITS_PER_BYTE * DIGIT_W;
	localparam int unsigned RANK_W          = 32;
	localparam int unsigned VALUE_WIDTH_DEF = 32;
	localparam int unsigned QUEUE_DEPTH     = 2;
	localparam int unsigned QUEUE_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned DIGIT_IDX_W     = $clog2(DIGITS_PER_BYTE);

	localparam logic [DIGIT_W-1:0] DIGIT_TERM = 2'd3;

	typedef logic [DIGIT_W-1:0] digit_t;

	// Classified code word as held in the queue
	typedef struct packed {
		digit_t [DIGITS_PER_BYTE-1:0] digits;
		logic   [DIGITS_PER_BYTE-1:0] term;
		logic   [DIGITS_PER_BYTE-1:0] last;
		logic                         stream_end;
	} tccd_entry_t;

	// Queue write side
	typedef struct packed {
		logic        push;
		tccd_entry_t entry;
	} tccd_push_t;

	// Queue read side towards the back end
	typedef struct packed {
		logic        valid;
		tccd_entry_t entry;
	} tccd_head_t;

endpackage

@@ rtl/core/tccd_byte_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Code byte channel
// Valid/ready channel carrying one code byte and its end-of-stream flag.
// ----------------------------------------------------------------------------
interface tccd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       stream_end;

	modport source (output valid, output code_byte, output stream_end, input ready);
	modport sink   (input valid, input code_byte, input stream_end, output ready);
endinterface

@@ rtl/core/tccd_rank_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank channel
// Valid/ready channel carrying one decoded rank with its flags.
// ----------------------------------------------------------------------------
interface tccd_rank_if;
	logic        valid;
	logic        ready;
	logic [31:0] rank_value;
	logic        rank_overflow;
	logic        last_of_byte;

	modport source (output valid, output rank_value, output rank_overflow,
		output last_of_byte, input ready);
	modport sink   (input valid, input rank_value, input rank_overflow,
		input last_of_byte, output ready);
endinterface

@@ rtl/core/ternary_comma_code_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ternary comma code decoder
// Decodes bytes of four 2-bit digits into bijective base-3 ranks; digit 3
// ends a codeword and releases its rank on the result channel.
// ----------------------------------------------------------------------------
// The decoder takes one code byte per word on code_ch and returns one word on
// rank_ch for each terminator digit, in digit order, with last_of_byte set on
// the final rank of that byte. The back end handles one digit per cycle, but a
// terminator digit waits while the output register holds an untaken rank. Each
// byte has all four digits stepped whether or not it yields ranks. A two-entry
// queue sits between the byte port and the digit sequencer, so bytes are taken
// while the back end is busy; a rank appears on rank_ch in the cycle after its
// terminator digit is stepped and is held there until taken. Ranks wrap
// at VALUE_WIDTH bits with rank_overflow set; only the low 32 bits are output.
// ----------------------------------------------------------------------------
module ternary_comma_code_decoder_core
	import tccd_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tccd_byte_if.sink   code_ch,
	tccd_rank_if.source rank_ch
);

	tccd_push_t push;
	tccd_head_t head;
	logic       full;
	logic       pop;

	tccd_front u_front (
		.code_ch (code_ch),
		.full    (full),
		.push    (push)
	);

	tccd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (full),
		.head   (head)
	);

	tccd_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.rank_ch (rank_ch)
	);

endmodule

@@ rtl/core/tccd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder front end
// Accepts code bytes, splits them into digits and marks terminators.
// ----------------------------------------------------------------------------
module tccd_front
	import tccd_pkg::*;
(
	tccd_byte_if.sink  code_ch,
	input  logic       full,
	output tccd_push_t push
);

	logic [DIGITS_PER_BYTE-1:0] term;
	logic [DIGITS_PER_BYTE-1:0] last;
	digit_t [DIGITS_PER_BYTE-1:0] digits;

	assign code_ch.ready = !full;

	always_comb begin
		logic later;
		later = 1'b0;
		for (int i = 0; i < DIGITS_PER_BYTE; i++) begin
			digits[i] = code_ch.code_byte[i*DIGIT_W +: DIGIT_W];
			term[i]   = (digits[i] == DIGIT_TERM);
		end
		// mark the final terminator of the word
		for (int i = DIGITS_PER_BYTE - 1; i >= 0; i--) begin
			last[i] = term[i] && !later;
			later   = later || term[i];
		end
	end

	assign push.push             = code_ch.valid && !full;
	assign push.entry.digits     = digits;
	assign push.entry.term       = term;
	assign push.entry.last       = last;
	assign push.entry.stream_end = code_ch.stream_end;

endmodule

@@ rtl/core/tccd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder word queue
// Short first-in first-out store between front end and back end.
// ----------------------------------------------------------------------------
module tccd_queue
	import tccd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  tccd_push_t push,
	input  logic       pop,
	output logic       full,
	output tccd_head_t head
);

	tccd_entry_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]    count_q;

	function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
		if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/tccd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder back end
// Steps through the digits of each queued word, builds the rank and drives
// the result register.
// ----------------------------------------------------------------------------
module tccd_back
	import tccd_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tccd_head_t  head,
	output logic        pop,
	tccd_rank_if.source rank_ch
);

	localparam int unsigned EXT_W = VALUE_WIDTH + 2;

	logic [DIGIT_IDX_W-1:0] idx_q;
	logic [VALUE_WIDTH-1:0] partial_q;
	logic                   partial_ovf_q;
	logic                   out_valid_q;
	logic [RANK_W-1:0]      out_rank_q;
	logic                   out_ovf_q;
	logic                   out_last_q;

	digit_t             digit;
	logic               is_term;
	logic               slot_free;
	logic               step;
	logic               word_done;
	logic [EXT_W-1:0]   grown;
	logic               grow_ovf;

	assign digit     = head.entry.digits[idx_q];
	assign is_term   = head.entry.term[idx_q];
	assign slot_free = !out_valid_q || rank_ch.ready;
	assign step      = head.valid && (!is_term || slot_free);
	assign word_done = (idx_q == DIGIT_IDX_W'(DIGITS_PER_BYTE - 1));
	assign pop       = step && word_done;

	// value*3 + digit + 1 with two guard bits to catch the wrap
	assign grown    = {2'b00, partial_q} + {1'b0, partial_q, 1'b0}
		+ EXT_W'({1'b0, digit} + 3'd1);
	assign grow_ovf = (grown[EXT_W-1 -: 2] != 2'b00);

	always_ff @(posedge clk) begin
		if (step && is_term) begin
			out_rank_q <= RANK_W'(partial_q);
			out_ovf_q  <= partial_ovf_q;
			out_last_q <= head.entry.last[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			partial_q     <= '0;
			partial_ovf_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (step) begin
				idx_q <= idx_q + 1'b1;
				if (is_term || (word_done && head.entry.stream_end)) begin
					partial_q     <= '0;
					partial_ovf_q <= 1'b0;
				end else begin
					partial_q     <= grown[VALUE_WIDTH-1:0];
					partial_ovf_q <= partial_ovf_q || grow_ovf;
				end
			end
			if (step && is_term) begin
				out_valid_q <= 1'b1;
			end else if (rank_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rank_ch.valid         = out_valid_q;
	assign rank_ch.rank_value    = out_rank_q;
	assign rank_ch.rank_overflow = out_ovf_q;
	assign rank_ch.last_of_byte  = out_last_q;

endmodule
